// ===== rtl/tmie_pkg.sv =====
// shared types, codes and constants for the tiny machine execute unit
package tmie_pkg;

  localparam int unsigned XLEN           = 32;
  localparam int unsigned NREGS          = 8;
  localparam int unsigned REG_IDX_W      = 3;
  localparam int unsigned FUNC_W         = 5;
  localparam int unsigned ARG1_W         = 4;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned PLEN_W         = 17;
  localparam int unsigned DMEM_WORDS_DEF = 1024;
  localparam int unsigned DIV_STEPS      = XLEN;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  // register 7 is the program counter
  localparam logic [REG_IDX_W-1:0] PC_IDX = 3'd7;
  // first argument of -1 marks the negative offset halt
  localparam logic [ARG1_W-1:0] ARG1_NEG_ONE = 4'hF;

  typedef enum logic [FUNC_W-1:0] {
    OP_HALT = 5'd0,
    OP_IN   = 5'd1,
    OP_OUT  = 5'd2,
    OP_ADD  = 5'd3,
    OP_SUB  = 5'd4,
    OP_MUL  = 5'd5,
    OP_DIV  = 5'd6,
    OP_LD   = 5'd7,
    OP_LDA  = 5'd8,
    OP_LDC  = 5'd9,
    OP_ST   = 5'd10,
    OP_JLT  = 5'd11,
    OP_JLE  = 5'd12,
    OP_JEQ  = 5'd13,
    OP_JNE  = 5'd14,
    OP_JGE  = 5'd15,
    OP_JGT  = 5'd16
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_HALTED     = 3'd1,
    ST_ADDR_FAULT = 3'd2,
    ST_NEG_OFFSET = 3'd3,
    ST_DIV_ZERO   = 3'd4,
    ST_PC_RANGE   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ_B,
    S_READ_A,
    S_EXEC,
    S_MEM,
    S_DIV_ABS_A,
    S_DIV_ABS_B,
    S_DIV_STEP,
    S_DIV_SIGN,
    S_FINISH
  } state_e;

  // request to the shared adder/subtractor
  typedef struct packed {
    logic            sub;
    logic [XLEN:0]   x;
    logic [XLEN:0]   y;
  } alu_req_t;

  // response of the shared adder/subtractor
  typedef struct packed {
    logic [XLEN:0]   sum;
    logic            borrow;
  } alu_rsp_t;

endpackage

// ===== rtl/tmie_if.sv =====
// channel interfaces for instruction, result and configuration transactions

interface tmie_in_if import tmie_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [FUNC_W-1:0]           func;
  logic signed [ARG1_W-1:0]    dest_reg;
  logic signed [XLEN-1:0]      offset_or_src;
  logic [REG_IDX_W-1:0]        base_or_src2;
  logic signed [XLEN-1:0]      in_value;

  modport source (output valid, func, dest_reg, offset_or_src, base_or_src2, in_value,
                  input ready);
  modport sink   (input valid, func, dest_reg, offset_or_src, base_or_src2, in_value,
                  output ready);
endinterface

interface tmie_out_if import tmie_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic signed [XLEN-1:0]      next_pc;
  logic                        out_valid;
  logic signed [XLEN-1:0]      out_value;

  modport source (output valid, status, next_pc, out_valid, out_value, input ready);
  modport sink   (input valid, status, next_pc, out_valid, out_value, output ready);
endinterface

interface tmie_cfg_if import tmie_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [PLEN_W-1:0]           data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/tiny_machine_instruction_execute.sv =====
// tiny machine instruction execute unit, top level
//
//  channel  dir  handshake         payload
//  in_i     in   valid / ready     func, dest_reg, offset_or_src, base_or_src2, in_value
//  out_o    out  valid / ready     status, next_pc, out_valid, out_value
//  cfg_i    in   valid / ready     data (program_length)
//
// one instruction at a time: the pace from one accept to the next is set by two
// reads of the register file through its single read port and by the shared adder,
// which does 32 restoring divide steps; LD adds a data memory read.
// after reset a clearing pass writes zero to all DMEM_WORDS data words, one per
// cycle, before the first instruction is taken; configuration is taken throughout.
// a finished result sits in the output register; the next result waits in its
// last cycle until that register is free.
module tiny_machine_instruction_execute import tmie_pkg::*; #(
  parameter int unsigned DMEM_WORDS = DMEM_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmie_in_if.sink     in_i,
  tmie_out_if.source  out_o,
  tmie_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = $clog2(DMEM_WORDS);

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_cnt_q, clr_cnt_d;
  logic [PLEN_W-1:0]      plen_q;
  logic [XLEN-1:0]        pc_q, pc_d;
  logic [NREGS-1:0]       rf_vld_q, rf_vld_d;

  // instruction fields
  logic [FUNC_W-1:0]      func_q, func_d;
  logic [ARG1_W-1:0]      arg1_q, arg1_d;
  logic [XLEN-1:0]        arg2_q, arg2_d;
  logic [REG_IDX_W-1:0]   arg3_q, arg3_d;
  logic [XLEN-1:0]        inval_q, inval_d;

  // operands and results
  logic [XLEN-1:0]        a_q, a_d;
  logic [XLEN-1:0]        b_q, b_d;
  logic [XLEN-1:0]        m_q, m_d;
  logic [XLEN-1:0]        res_q, res_d;
  status_e                status_q, status_d;
  logic                   wr_en_q, wr_en_d;
  logic                   jump_q, jump_d;
  logic                   oflag_q, oflag_d;

  // divider
  logic [XLEN-1:0]        rem_q, rem_d;
  logic [XLEN-1:0]        quo_q, quo_d;
  logic [XLEN-1:0]        dvs_q, dvs_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;

  // output register
  logic                   ovld_q, ovld_d;
  status_e                ostat_q, ostat_d;
  logic [XLEN-1:0]        opc_q, opc_d;
  logic                   oflg_q, oflg_d;
  logic [XLEN-1:0]        oval_q, oval_d;

  // decode and helpers
  logic                   in_hs;
  logic                   fin_go;
  logic                   use_src;
  logic [REG_IDX_W-1:0]   dst_idx;
  logic [REG_IDX_W-1:0]   rd2_idx;
  logic [REG_IDX_W-1:0]   sel_idx;
  logic [REG_IDX_W-1:0]   rf_raddr;
  logic [XLEN-1:0]        rf_rdata;
  logic [XLEN-1:0]        rf_val;
  logic                   rf_we;
  logic                   addr_fault;
  logic                   ge;
  logic                   jcond;
  logic [XLEN-1:0]        mul_lo;
  logic [XLEN-1:0]        final_pc;
  status_e                final_status;

  logic                   dm_we;
  logic [AW-1:0]          dm_waddr;
  logic [XLEN-1:0]        dm_wdata;
  logic [XLEN-1:0]        dm_rdata;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;

  assign in_hs    = in_i.valid & in_i.ready;
  assign fin_go   = ~ovld_q | out_o.ready;
  assign dst_idx  = arg1_q[REG_IDX_W-1:0];
  assign use_src  = (func_q == OP_ADD) | (func_q == OP_SUB) |
                    (func_q == OP_MUL) | (func_q == OP_DIV);
  assign rd2_idx  = use_src ? arg2_q[REG_IDX_W-1:0] : dst_idx;
  assign sel_idx  = (state_q == S_READ_B) ? arg3_q : rd2_idx;
  assign rf_raddr = (state_q == S_IDLE) ? in_i.base_or_src2 : rd2_idx;
  assign addr_fault = (m_q >= XLEN'(DMEM_WORDS));
  assign ge       = ~alu_rsp.borrow;
  assign mul_lo   = a_q * b_q;

  // register value: pc for register 7, zero until first written
  always_comb begin
    if (sel_idx == PC_IDX) begin
      rf_val = pc_q;
    end else if (rf_vld_q[sel_idx]) begin
      rf_val = rf_rdata;
    end else begin
      rf_val = '0;
    end
  end

  // jump condition on the tested register
  always_comb begin
    case (func_q)
      OP_JLT:  jcond = a_q[XLEN-1];
      OP_JLE:  jcond = a_q[XLEN-1] | (a_q == '0);
      OP_JEQ:  jcond = (a_q == '0);
      OP_JNE:  jcond = (a_q != '0);
      OP_JGE:  jcond = ~a_q[XLEN-1];
      OP_JGT:  jcond = ~a_q[XLEN-1] & (a_q != '0);
      default: jcond = 1'b0;
    endcase
  end

  // pc and status as they stand after the instruction
  always_comb begin
    if (wr_en_q && (dst_idx == PC_IDX)) begin
      final_pc = res_q;
    end else if (jump_q) begin
      final_pc = m_q;
    end else begin
      final_pc = pc_q;
    end
    if ((status_q == ST_OK) && (final_pc >= XLEN'(plen_q))) begin
      final_status = ST_PC_RANGE;
    end else begin
      final_status = status_q;
    end
  end

  // shared adder operand selection
  always_comb begin
    alu_req = '0;
    unique case (state_q)
      S_IDLE: begin
        alu_req.x = {1'b0, pc_q};
        alu_req.y = {{XLEN{1'b0}}, 1'b1};
      end
      S_READ_B: begin
        alu_req.x = {1'b0, arg2_q};
        alu_req.y = {1'b0, rf_val};
      end
      S_EXEC: begin
        alu_req.sub = (func_q == OP_SUB);
        alu_req.x   = {1'b0, a_q};
        alu_req.y   = {1'b0, b_q};
      end
      S_DIV_ABS_A: begin
        alu_req.sub = 1'b1;
        alu_req.y   = {1'b0, a_q};
      end
      S_DIV_ABS_B: begin
        alu_req.sub = 1'b1;
        alu_req.y   = {1'b0, b_q};
      end
      S_DIV_STEP: begin
        alu_req.sub = 1'b1;
        alu_req.x   = {rem_q, quo_q[XLEN-1]};
        alu_req.y   = {1'b0, dvs_q};
      end
      S_DIV_SIGN: begin
        alu_req.sub = 1'b1;
        alu_req.y   = {1'b0, quo_q};
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  tmie_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_cnt_q == AW'(DMEM_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_hs) state_d = S_READ_B;
      end
      S_READ_B: state_d = S_READ_A;
      S_READ_A: state_d = S_EXEC;
      S_EXEC: begin
        if ((func_q == OP_LD) && !addr_fault) begin
          state_d = S_MEM;
        end else if ((func_q == OP_DIV) && (b_q != '0)) begin
          state_d = S_DIV_ABS_A;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_MEM:       state_d = S_FINISH;
      S_DIV_ABS_A: state_d = S_DIV_ABS_B;
      S_DIV_ABS_B: state_d = S_DIV_STEP;
      S_DIV_STEP: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_DIV_SIGN;
      end
      S_DIV_SIGN: state_d = S_FINISH;
      S_FINISH: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // memory and register file write controls
  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = m_q[AW-1:0];
    dm_wdata = a_q;
    rf_we    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        dm_we    = 1'b1;
        dm_waddr = clr_cnt_q;
        dm_wdata = '0;
      end
      S_EXEC: begin
        dm_we = (func_q == OP_ST) & ~addr_fault;
      end
      S_FINISH: begin
        rf_we = fin_go & wr_en_q & (dst_idx != PC_IDX);
      end
      default: begin
        dm_we = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    pc_d      = pc_q;
    rf_vld_d  = rf_vld_q;
    func_d    = func_q;
    arg1_d    = arg1_q;
    arg2_d    = arg2_q;
    arg3_d    = arg3_q;
    inval_d   = inval_q;
    a_d       = a_q;
    b_d       = b_q;
    m_d       = m_q;
    res_d     = res_q;
    status_d  = status_q;
    wr_en_d   = wr_en_q;
    jump_d    = jump_q;
    oflag_d   = oflag_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    div_cnt_d = div_cnt_q;
    ovld_d    = ovld_q & ~out_o.ready;
    ostat_d   = ostat_q;
    opc_d     = opc_q;
    oflg_d    = oflg_q;
    oval_d    = oval_q;

    unique case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AW'(1);
      end
      // take the instruction and step the pc
      S_IDLE: begin
        if (in_hs) begin
          func_d  = in_i.func;
          arg1_d  = in_i.dest_reg;
          arg2_d  = in_i.offset_or_src;
          arg3_d  = in_i.base_or_src2;
          inval_d = in_i.in_value;
          pc_d    = alu_rsp.sum[XLEN-1:0];
        end
      end
      // base register and effective address
      S_READ_B: begin
        b_d = rf_val;
        m_d = alu_rsp.sum[XLEN-1:0];
      end
      S_READ_A: begin
        a_d = rf_val;
      end
      // execute the operation
      S_EXEC: begin
        status_d = ST_OK;
        wr_en_d  = 1'b0;
        jump_d   = 1'b0;
        oflag_d  = 1'b0;
        unique case (func_q) inside
          OP_HALT: begin
            status_d = (arg1_q == ARG1_NEG_ONE) ? ST_NEG_OFFSET : ST_HALTED;
          end
          OP_IN: begin
            res_d   = inval_q;
            wr_en_d = 1'b1;
          end
          OP_OUT: begin
            oflag_d = 1'b1;
          end
          OP_ADD, OP_SUB: begin
            res_d   = alu_rsp.sum[XLEN-1:0];
            wr_en_d = 1'b1;
          end
          OP_MUL: begin
            res_d   = mul_lo;
            wr_en_d = 1'b1;
          end
          OP_DIV: begin
            if (b_q == '0) status_d = ST_DIV_ZERO;
          end
          OP_LD, OP_ST: begin
            if (addr_fault) status_d = ST_ADDR_FAULT;
          end
          OP_LDA: begin
            res_d   = m_q;
            wr_en_d = 1'b1;
          end
          OP_LDC: begin
            res_d   = arg2_q;
            wr_en_d = 1'b1;
          end
          [OP_JLT:OP_JGT]: begin
            jump_d = jcond;
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      S_MEM: begin
        res_d   = dm_rdata;
        wr_en_d = 1'b1;
      end
      // divide on magnitudes, one quotient bit per cycle
      S_DIV_ABS_A: begin
        quo_d = a_q[XLEN-1] ? alu_rsp.sum[XLEN-1:0] : a_q;
      end
      S_DIV_ABS_B: begin
        dvs_d     = b_q[XLEN-1] ? alu_rsp.sum[XLEN-1:0] : b_q;
        rem_d     = '0;
        div_cnt_d = '0;
      end
      S_DIV_STEP: begin
        rem_d     = ge ? alu_rsp.sum[XLEN-1:0] : {rem_q[XLEN-2:0], quo_q[XLEN-1]};
        quo_d     = {quo_q[XLEN-2:0], ge};
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      S_DIV_SIGN: begin
        res_d   = (a_q[XLEN-1] ^ b_q[XLEN-1]) ? alu_rsp.sum[XLEN-1:0] : quo_q;
        wr_en_d = 1'b1;
      end
      // commit and present the result
      S_FINISH: begin
        if (fin_go) begin
          pc_d    = final_pc;
          ovld_d  = 1'b1;
          ostat_d = final_status;
          opc_d   = final_pc;
          oflg_d  = oflag_q;
          oval_d  = oflag_q ? a_q : '0;
          if (rf_we) rf_vld_d[dst_idx] = 1'b1;
        end
      end
      default: begin
        clr_cnt_d = clr_cnt_q;
      end
    endcase
  end

  tmie_ram #(
    .WIDTH (XLEN),
    .DEPTH (NREGS)
  ) u_regfile (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (dst_idx),
    .wdata_i (res_q),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  tmie_ram #(
    .WIDTH (XLEN),
    .DEPTH (DMEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .raddr_i (m_q[AW-1:0]),
    .rdata_o (dm_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      plen_q    <= '0;
      pc_q      <= '0;
      rf_vld_q  <= '0;
      ovld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      pc_q      <= pc_d;
      rf_vld_q  <= rf_vld_d;
      ovld_q    <= ovld_d;
      if (cfg_i.valid && cfg_i.ready) plen_q <= cfg_i.data;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    arg1_q    <= arg1_d;
    arg2_q    <= arg2_d;
    arg3_q    <= arg3_d;
    inval_q   <= inval_d;
    a_q       <= a_d;
    b_q       <= b_d;
    m_q       <= m_d;
    res_q     <= res_d;
    status_q  <= status_d;
    wr_en_q   <= wr_en_d;
    jump_q    <= jump_d;
    oflag_q   <= oflag_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    dvs_q     <= dvs_d;
    div_cnt_q <= div_cnt_d;
    ostat_q   <= ostat_d;
    opc_q     <= opc_d;
    oflg_q    <= oflg_d;
    oval_q    <= oval_d;
  end

  // channel outputs
  assign in_i.ready      = (state_q == S_IDLE);
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = ovld_q;
  assign out_o.status    = ostat_q;
  assign out_o.next_pc   = opc_q;
  assign out_o.out_valid = oflg_q;
  assign out_o.out_value = oval_q;

endmodule

// ===== rtl/tmie_ram.sv =====
// generic single write port ram with registered read
module tmie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tmie_alu.sv =====
// shared 33-bit adder/subtractor with borrow flag
module tmie_alu import tmie_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [XLEN+1:0] full;
  logic [XLEN:0]   y_op;

  // two's complement subtract as add of inverted operand plus one
  always_comb begin
    y_op         = req_i.sub ? ~req_i.y : req_i.y;
    full         = {1'b0, req_i.x} + {1'b0, y_op} + {{(XLEN+1){1'b0}}, req_i.sub};
    rsp_o.sum    = full[XLEN:0];
    rsp_o.borrow = req_i.sub & ~full[XLEN+1];
  end

endmodule

// ===== rtl/tmie_checker.sv =====
// port level checks for the execute unit, bound to the top level
module tmie_checker import tmie_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic [STATUS_W-1:0] res_status_i,
  input logic [XLEN-1:0]     res_next_pc_i,
  input logic                res_out_valid_i,
  input logic [XLEN-1:0]     res_out_value_i
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_status_i) &&
      $stable(res_next_pc_i) && $stable(res_out_valid_i) && $stable(res_out_value_i))
  else $error("result changed while stalled");

  // no out value without the out flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_out_valid_i |-> res_out_value_i == '0)
  else $error("out value set without out flag");

  // an instruction in flight blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
  else $error("ready right after an accepted instruction");

  // an OUT instruction ends only ok or with the pc out of range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_out_valid_i |-> res_status_i == ST_OK || res_status_i == ST_PC_RANGE)
  else $error("out value with an error status");

endmodule

bind tiny_machine_instruction_execute tmie_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .res_valid_i     (out_o.valid),
  .res_ready_i     (out_o.ready),
  .res_status_i    (out_o.status),
  .res_next_pc_i   (out_o.next_pc),
  .res_out_valid_i (out_o.out_valid),
  .res_out_value_i (out_o.out_value)
);
